// ----- sv/wpm_pkg.sv -----
// Shared types, codes and helpers for the WAV stream to mono decoder.
package wpm_pkg;

  localparam int MAX_CHANNELS    = 256;
  localparam int MAX_SAMPLE_BITS = 32;
  localparam int HEADER_BYTES    = 36;
  localparam int FMT_BASE        = 16;
  localparam int DIV_W           = 40;
  localparam int DVS_W           = 22;
  localparam int OFIFO_DEPTH     = 4;

  localparam logic [24:0] SAMPLE_LIMIT_RST = 25'd28800000;
  localparam logic [7:0]  SCAN_LIMIT_RST   = 8'd20;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  typedef enum logic {
    REG_SAMPLE_LIMIT = 1'b0,
    REG_SCAN_LIMIT   = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_MAGIC    = 4'd1,
    ERR_NOT_PCM  = 4'd2,
    ERR_FIELDS   = 4'd3,
    ERR_CHANNELS = 4'd4,
    ERR_NO_DATA  = 4'd5,
    ERR_EMPTY    = 4'd6,
    ERR_DEPTH    = 4'd7,
    ERR_TRUNC    = 4'd8
  } err_e;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_FMTSKIP   = 3'd1,
    PH_CHUNKHDR  = 3'd2,
    PH_CHUNKSKIP = 3'd3,
    PH_DATA      = 3'd4,
    PH_DRAIN     = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_FGO   = 3'd1,
    S_FWAIT = 3'd2,
    S_SGO   = 3'd3,
    S_SWAIT = 3'd4,
    S_DONE  = 3'd5,
    S_FIN   = 3'd6
  } ctrl_state_e;

  typedef enum logic [1:0] {
    STEP_NONE  = 2'd0,
    STEP_FAIL  = 2'd1,
    STEP_BEGIN = 2'd2,
    STEP_FRAME = 2'd3
  } step_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] sample_value;
    logic [30:0]        sample_rate;
    logic [8:0]         channel_count;
    logic [5:0]         bits_per_sample;
    logic [24:0]        sample_count;
    logic [3:0]         error_code;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic frm_go;
    logic frm_end;
    logic smp_go;
    logic smp_end;
    logic done_push;
    logic fin;
  } wpm_cmd_t;

  typedef struct packed {
    step_e step_kind;
    logic  frm_more;
    logic  smp_last;
  } wpm_sts_t;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    return tag[{~idx, 3'b000} +: 8];
  endfunction

  function automatic out_item_t mk_err(input err_e code);
    out_item_t it;
    it = '0;
    it.result_kind = KIND_ERROR;
    it.error_code  = code;
    it.last        = 1'b1;
    return it;
  endfunction

  function automatic out_item_t mk_done(input logic [24:0] count);
    out_item_t it;
    it = '0;
    it.result_kind  = KIND_DONE;
    it.sample_count = count;
    it.last         = 1'b1;
    return it;
  endfunction

endpackage

// ----- sv/wpm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module wpm_div import wpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quot_o,
  output logic             done_o
);

  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 6'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ----- sv/wpm_ofifo.sv -----
// Four-entry result queue between the decoder and the output channel.
module wpm_ofifo import wpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  input  logic      pop_i,
  output logic      valid_o,
  output out_item_t item_o,
  output logic [2:0] level_o
);

  out_item_t  mem_q [OFIFO_DEPTH];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b00, push_i} - {2'b00, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign valid_o = (cnt_q != 3'd0);
  assign item_o  = mem_q[rd_q];
  assign level_o = cnt_q;

endmodule

// ----- sv/wpm_dp.sv -----
// Parse datapath: header fields, chunk scan, sample assembly and frame sums.
module wpm_dp import wpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_item_t         in_item_i,
  input  logic [24:0]      sample_limit_i,
  input  logic [7:0]       scan_limit_i,
  input  wpm_cmd_t         cmd_i,
  output wpm_sts_t         sts_o,
  output logic [DIV_W-1:0] div_dividend_o,
  output logic [DVS_W-1:0] div_divisor_o,
  input  logic [DIV_W-1:0] div_quot_i,
  output logic             push_o,
  output out_item_t        push_item_o
);

  phase_e      phase_q;
  logic [5:0]  pos_q;
  logic        magic_q, tag_ok_q, eos_q, neg_q;
  logic [31:0] fmt_q, rate_q, csize_q, skip_q, asm_q;
  logic [15:0] format_q, chan_q, bits_q;
  logic [7:0]  scan_q;
  logic [39:0] sum_q;
  logic [8:0]  idx_q;
  logic [24:0] target_q, emitted_q;

  logic [7:0]  b;
  logic        magic_n;
  logic [31:0] fmt_n, rate_n, csize_n, raw_n;
  logic [15:0] format_n, chan_n, bits_n;
  err_e        hdr_err, fail_code;
  logic        hdr_last, chunk_last, tag_n, smp_end, frame_end, bits_ok;
  logic [7:0]  scan_n, lim;
  logic [2:0]  bps;
  logic [39:0] q31, sum_n, sum_abs;
  logic [8:0]  idx_n;
  step_e       step_kind;
  logic [31:0] qf, qs, sval;
  logic [24:0] tgt;
  logic [21:0] frame_bytes;

  assign b = in_item_i.byte_value;

  // header field capture
  always_comb begin
    magic_n  = magic_q;
    fmt_n    = fmt_q;
    format_n = format_q;
    chan_n   = chan_q;
    rate_n   = rate_q;
    bits_n   = bits_q;
    if (pos_q < 6'd4) begin
      if (b != tag_byte(TAG_RIFF, pos_q[1:0])) magic_n = 1'b1;
    end else if (pos_q >= 6'd8 && pos_q < 6'd12) begin
      if (b != tag_byte(TAG_WAVE, pos_q[1:0])) magic_n = 1'b1;
    end else if (pos_q >= 6'd16 && pos_q < 6'd20) begin
      fmt_n[{pos_q[1:0], 3'b000} +: 8] = b;
    end else if (pos_q >= 6'd20 && pos_q < 6'd22) begin
      format_n[{pos_q[0], 3'b000} +: 8] = b;
    end else if (pos_q >= 6'd22 && pos_q < 6'd24) begin
      chan_n[{pos_q[0], 3'b000} +: 8] = b;
    end else if (pos_q >= 6'd24 && pos_q < 6'd28) begin
      rate_n[{pos_q[1:0], 3'b000} +: 8] = b;
    end else if (pos_q >= 6'd34 && pos_q < 6'd36) begin
      bits_n[{pos_q[0], 3'b000} +: 8] = b;
    end
  end

  always_comb begin
    if (magic_n) hdr_err = ERR_MAGIC;
    else if (format_n != 16'd1) hdr_err = ERR_NOT_PCM;
    else if (rate_n == 32'd0 || rate_n[31] || chan_n == 16'd0 || bits_n < 16'd8)
      hdr_err = ERR_FIELDS;
    else if (chan_n > 16'(MAX_CHANNELS)) hdr_err = ERR_CHANNELS;
    else hdr_err = ERR_NONE;
  end

  assign hdr_last = (pos_q == 6'(HEADER_BYTES - 1));

  // chunk header
  assign chunk_last = (pos_q == 6'd7);
  assign tag_n  = tag_ok_q && (pos_q >= 6'd4 || b == tag_byte(TAG_DATA, pos_q[1:0]));
  assign scan_n = (scan_q == 8'hFF) ? scan_q : scan_q + 8'd1;
  assign lim    = (scan_limit_i == 8'd0) ? 8'd1 : scan_limit_i;

  always_comb begin
    csize_n = csize_q;
    if (pos_q >= 6'd4) csize_n[{pos_q[1:0], 3'b000} +: 8] = b;
  end

  // sample assembly and Q1.31 scaling
  assign bps     = bits_q[5:3];
  assign smp_end = (6'(pos_q + 6'd1) == {3'b000, bps});

  always_comb begin
    raw_n = asm_q;
    raw_n[{pos_q[1:0], 3'b000} +: 8] = b;
  end

  always_comb begin
    unique case (bits_q[5:0])
      6'd8:    q31 = {{9{~raw_n[7]}}, raw_n[6:0], 24'd0};
      6'd16:   q31 = {{8{raw_n[15]}}, raw_n[15:0], 16'd0};
      6'd24:   q31 = {{8{raw_n[23]}}, raw_n[23:0], 8'd0};
      default: q31 = {{8{raw_n[31]}}, raw_n};
    endcase
  end

  assign sum_n     = sum_q + q31;
  assign idx_n     = idx_q + 9'd1;
  assign frame_end = smp_end && (idx_n == chan_q[8:0]);

  always_comb begin
    step_kind = STEP_NONE;
    fail_code = ERR_NONE;
    unique case (phase_q) inside
      PH_HEADER: begin
        if (hdr_last && hdr_err != ERR_NONE) begin
          step_kind = STEP_FAIL;
          fail_code = hdr_err;
        end
      end
      PH_CHUNKHDR: begin
        if (chunk_last) begin
          if (tag_n) step_kind = STEP_BEGIN;
          else if (scan_n >= lim) begin
            step_kind = STEP_FAIL;
            fail_code = ERR_NO_DATA;
          end
        end
      end
      PH_DATA: begin
        if (frame_end) step_kind = STEP_FRAME;
      end
      default: step_kind = STEP_NONE;
    endcase
  end

  // divisions: frame count at the data chunk, then one per frame
  assign bits_ok = (bits_q == 16'd8 || bits_q == 16'd16 || bits_q == 16'd24 ||
                    bits_q == 16'd32) && bits_q <= 16'(MAX_SAMPLE_BITS);
  assign frame_bytes = {13'd0, chan_q[8:0]} * {9'd0, bits_q[15:3]};
  assign sum_abs = sum_q[39] ? (~sum_q + 40'd1) : sum_q;
  assign qf      = div_quot_i[31:0];
  assign qs      = div_quot_i[31:0];
  assign sval    = neg_q ? (~qs + 32'd1) : qs;
  assign tgt     = (qf < {7'd0, sample_limit_i}) ? qf[24:0] : sample_limit_i;

  assign div_dividend_o = cmd_i.frm_go ? {8'd0, csize_q} : sum_abs;
  assign div_divisor_o  = cmd_i.frm_go ? frame_bytes : {13'd0, chan_q[8:0]};

  assign sts_o.step_kind = step_kind;
  assign sts_o.frm_more  = (qf != 32'd0) && bits_ok && (sample_limit_i == 25'd0);
  assign sts_o.smp_last  = ({1'b0, emitted_q} + 26'd1) >= {1'b0, target_q};

  always_comb begin
    push_o      = 1'b0;
    push_item_o = '0;
    if (cmd_i.step && step_kind == STEP_FAIL) begin
      push_o      = 1'b1;
      push_item_o = mk_err(fail_code);
    end else if (cmd_i.frm_end) begin
      push_o = 1'b1;
      if (qf == 32'd0) push_item_o = mk_err(ERR_EMPTY);
      else if (!bits_ok) push_item_o = mk_err(ERR_DEPTH);
      else begin
        push_item_o.result_kind     = KIND_FORMAT;
        push_item_o.sample_rate     = rate_q[30:0];
        push_item_o.channel_count   = chan_q[8:0];
        push_item_o.bits_per_sample = bits_q[5:0];
      end
    end else if (cmd_i.smp_end) begin
      push_o                   = 1'b1;
      push_item_o.result_kind  = KIND_SAMPLE;
      push_item_o.sample_value = sval;
      push_item_o.sample_count = emitted_q + 25'd1;
    end else if (cmd_i.done_push) begin
      push_o      = 1'b1;
      push_item_o = mk_done(emitted_q);
    end else if (cmd_i.fin && eos_q) begin
      unique case (phase_q) inside
        PH_HEADER: begin
          push_o      = 1'b1;
          push_item_o = mk_err(ERR_TRUNC);
        end
        PH_DATA: begin
          push_o      = 1'b1;
          push_item_o = mk_done(emitted_q);
        end
        PH_DRAIN: push_o = 1'b0;
        default: begin
          push_o      = 1'b1;
          push_item_o = mk_err(ERR_NO_DATA);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      magic_q   <= 1'b0;
      fmt_q     <= '0;
      format_q  <= '0;
      chan_q    <= '0;
      rate_q    <= '0;
      bits_q    <= '0;
      csize_q   <= '0;
      skip_q    <= '0;
      scan_q    <= '0;
      tag_ok_q  <= 1'b1;
      asm_q     <= '0;
      sum_q     <= '0;
      idx_q     <= '0;
      target_q  <= '0;
      emitted_q <= '0;
      eos_q     <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        eos_q <= in_item_i.end_of_stream;
        unique case (phase_q) inside
          PH_HEADER: begin
            magic_q  <= magic_n;
            fmt_q    <= fmt_n;
            format_q <= format_n;
            chan_q   <= chan_n;
            rate_q   <= rate_n;
            bits_q   <= bits_n;
            pos_q    <= pos_q + 6'd1;
            if (hdr_last) begin
              pos_q <= '0;
              if (hdr_err != ERR_NONE) phase_q <= PH_DRAIN;
              else if (fmt_n > 32'(FMT_BASE)) begin
                skip_q  <= fmt_n - 32'(FMT_BASE);
                phase_q <= PH_FMTSKIP;
              end else begin
                phase_q  <= PH_CHUNKHDR;
                csize_q  <= '0;
                tag_ok_q <= 1'b1;
              end
            end
          end
          PH_FMTSKIP, PH_CHUNKSKIP: begin
            skip_q <= (skip_q == 32'd0) ? 32'd0 : skip_q - 32'd1;
            if (skip_q <= 32'd1) begin
              phase_q  <= PH_CHUNKHDR;
              pos_q    <= '0;
              csize_q  <= '0;
              tag_ok_q <= 1'b1;
            end
          end
          PH_CHUNKHDR: begin
            pos_q    <= pos_q + 6'd1;
            tag_ok_q <= tag_n;
            csize_q  <= csize_n;
            if (chunk_last) begin
              scan_q <= scan_n;
              if (!tag_n) begin
                if (scan_n >= lim) phase_q <= PH_DRAIN;
                else if (csize_n == 32'd0) begin
                  pos_q    <= '0;
                  csize_q  <= '0;
                  tag_ok_q <= 1'b1;
                end else begin
                  skip_q  <= csize_n;
                  phase_q <= PH_CHUNKSKIP;
                end
              end
            end
          end
          PH_DATA: begin
            if (smp_end) begin
              asm_q <= '0;
              pos_q <= '0;
              sum_q <= sum_n;
              idx_q <= idx_n;
            end else begin
              asm_q <= raw_n;
              pos_q <= pos_q + 6'd1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.smp_go) neg_q <= sum_q[39];
      if (cmd_i.frm_end) begin
        if (qf == 32'd0 || !bits_ok) phase_q <= PH_DRAIN;
        else begin
          target_q <= tgt;
          phase_q  <= PH_DATA;
          pos_q    <= '0;
          idx_q    <= '0;
          sum_q    <= '0;
          asm_q    <= '0;
        end
      end
      if (cmd_i.smp_end) begin
        emitted_q <= emitted_q + 25'd1;
        sum_q     <= '0;
        idx_q     <= '0;
      end
      if (cmd_i.done_push) phase_q <= PH_DRAIN;
      if (cmd_i.fin && eos_q) begin
        phase_q   <= PH_HEADER;
        pos_q     <= '0;
        magic_q   <= 1'b0;
        fmt_q     <= '0;
        format_q  <= '0;
        chan_q    <= '0;
        rate_q    <= '0;
        bits_q    <= '0;
        csize_q   <= '0;
        skip_q    <= '0;
        scan_q    <= '0;
        tag_ok_q  <= 1'b1;
        asm_q     <= '0;
        sum_q     <= '0;
        idx_q     <= '0;
        target_q  <= '0;
        emitted_q <= '0;
        eos_q     <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/wpm_ctrl.sv -----
// Sequencer: byte step, divider runs, trailing done and end-of-stream handling.
module wpm_ctrl import wpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     room_i,
  input  logic     div_done_i,
  input  wpm_sts_t sts_i,
  output logic     in_ready_o,
  output wpm_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = room_i;
        if (in_valid_i && room_i) begin
          cmd_o.step = 1'b1;
          unique case (sts_i.step_kind)
            STEP_BEGIN: state_d = S_FGO;
            STEP_FRAME: state_d = S_SGO;
            default:    state_d = S_FIN;
          endcase
        end
      end
      S_FGO: begin
        cmd_o.frm_go = 1'b1;
        state_d      = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done_i) begin
          cmd_o.frm_end = 1'b1;
          state_d       = sts_i.frm_more ? S_DONE : S_FIN;
        end
      end
      S_SGO: begin
        cmd_o.smp_go = 1'b1;
        state_d      = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_done_i) begin
          cmd_o.smp_end = 1'b1;
          state_d       = sts_i.smp_last ? S_DONE : S_FIN;
        end
      end
      S_DONE: begin
        cmd_o.done_push = 1'b1;
        state_d         = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- sv/wav_pcm_stream_to_mono_core.sv -----
// Top level of the WAV byte stream decoder with mono downmix.
//
//  channel | direction | handshake        | payload
//  in      | request   | in_valid/ready   | in_item_t: byte_value, end_of_stream
//  out     | result    | out_valid/ready  | out_item_t: kind, sample, format, count, error
//  cfg     | APB write | psel/penable     | sample_limit @0x0, chunk_scan_limit @0x4
//
// Most bytes pass through a step state, then an end-of-stream check.
// A byte that closes a frame or the data chunk header also waits on the divider:
// the shared 40-iteration divider runs once for the average or the frame count.
// Results go to a 4-entry queue; a new byte is taken while results wait,
// as long as two entries are free. Reset clears all parse state at once.
module wav_pcm_stream_to_mono_core import wpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [24:0] sample_limit_q;
  logic [7:0]  scan_limit_q;
  logic        cfg_wr;
  reg_idx_e    reg_idx;

  wpm_cmd_t         cmd;
  wpm_sts_t         sts;
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done, push, pop, room;
  out_item_t        push_item;
  logic [2:0]       fifo_level;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_limit_q <= SAMPLE_LIMIT_RST;
      scan_limit_q   <= SCAN_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SAMPLE_LIMIT: sample_limit_q <= pwdata[24:0];
        REG_SCAN_LIMIT:   scan_limit_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_LIMIT: prdata = {7'd0, sample_limit_q};
      REG_SCAN_LIMIT:   prdata = {24'd0, scan_limit_q};
      default:          prdata = '0;
    endcase
  end

  assign room = (fifo_level <= 3'(OFIFO_DEPTH - 2));
  assign pop  = out_valid_o && out_ready_i;

  wpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .room_i     (room),
    .div_done_i (div_done),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  wpm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .sample_limit_i (sample_limit_q),
    .scan_limit_i   (scan_limit_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_quot_i     (div_quot),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  wpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.frm_go || cmd.smp_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  wpm_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .item_o  (out_item_o),
    .level_o (fifo_level)
  );

  // one byte at a time: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while a byte is still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (fifo_level != 3'(OFIFO_DEPTH)))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> !in_ready_o)
    else $error("divider finished while sequencer idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && reg_idx == REG_SAMPLE_LIMIT) |=> (sample_limit_q == $past(pwdata[24:0])))
    else $error("sample limit write lost");

endmodule
